[sv/olad_pkg.sv]
`timescale 1ns / 1ps

package olad_pkg;

    // Default number of list entries.
    localparam int DEPTH_DEFAULT = 16;

    // Request codes.
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_LIST,
        S_RESP
    } t_state;

endpackage

[sv/ordered_list_append_delete.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit items kept in one synchronous RAM.
// Input channel (i_valid/o_ready) carries i_action and i_value; the output
// channel (o_valid/i_ready) carries o_item, o_last and o_status.
// One request is worked on at a time; o_ready is high only while the
// sequencer waits for a request, also while the last result still waits.
// Append: one status transfer, produced from the response state.
// Delete: the RAM is scanned one entry per cycle until the first match, then
// the entries behind it move up one place per cycle; the status transfer
// follows the last shift, or the end of the scan when no entry matches.
// The single RAM port pair (one read, one write per cycle) sets this pace.
// List: one transfer per item, one per cycle while the output register is
// free, last marked.
// An empty list, a full list or a missing value gives one status transfer.
// Action code three is dropped without any result.
// When the receiver stalls, the output register holds its transfer and the
// sequencer waits before producing the next one; nothing is lost.
// Reset empties the list and clears the output valid flag; the RAM is not
// cleared, since no entry is used before it is written.
module ordered_list_append_delete #(
    parameter int DEPTH = olad_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_item,
    output logic               o_last,
    output logic [1:0]         o_status
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Storage.
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_q;

    // Control and working registers.
    olad_pkg::t_state   r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_idx, n_idx;
    logic signed [31:0] r_value;
    logic [1:0]         r_status, n_status;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_item;
    logic               r_out_last;
    logic [1:0]         r_out_status;

    // RAM access and emit controls.
    logic               rd_en, wr_en;
    logic [IW-1:0]      rd_addr, wr_addr;
    logic signed [31:0] wr_data;
    logic               emit;
    logic signed [31:0] emit_item;
    logic               emit_last;

    logic               accept, out_free, at_last, match, is_full, is_empty;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign at_last  = ((CW'(r_idx) + CW'(1)) == r_count);
    assign match    = (r_q == r_value);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    assign o_ready  = (r_state == olad_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_item   = r_out_item;
    assign o_last   = r_out_last;
    assign o_status = r_out_status;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            olad_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        olad_pkg::ACT_APPEND: n_state = olad_pkg::S_RESP;
                        olad_pkg::ACT_DELETE:
                            n_state = is_empty ? olad_pkg::S_RESP : olad_pkg::S_SEARCH;
                        olad_pkg::ACT_LIST:
                            n_state = is_empty ? olad_pkg::S_RESP : olad_pkg::S_LIST;
                        default: n_state = olad_pkg::S_IDLE;
                    endcase
                end
            end
            olad_pkg::S_SEARCH: begin
                if (match) begin
                    n_state = olad_pkg::S_SHIFT;
                end else if (at_last) begin
                    n_state = olad_pkg::S_RESP;
                end
            end
            olad_pkg::S_SHIFT: begin
                if (at_last) begin
                    n_state = olad_pkg::S_RESP;
                end
            end
            olad_pkg::S_LIST: begin
                if (out_free && at_last) begin
                    n_state = olad_pkg::S_IDLE;
                end
            end
            olad_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = olad_pkg::S_IDLE;
                end
            end
            default: n_state = olad_pkg::S_IDLE;
        endcase
    end

    // Datapath controls per state.
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_status  = r_status;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        wr_en     = 1'b0;
        wr_addr   = r_idx;
        wr_data   = r_q;
        emit      = 1'b0;
        emit_item = '0;
        emit_last = 1'b1;
        case (r_state)
            olad_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        olad_pkg::ACT_APPEND: begin
                            if (is_full) begin
                                n_status = olad_pkg::STAT_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = r_count[IW-1:0];
                                wr_data  = i_value;
                                n_count  = r_count + CW'(1);
                                n_status = olad_pkg::STAT_OK;
                            end
                        end
                        olad_pkg::ACT_DELETE, olad_pkg::ACT_LIST: begin
                            n_status = olad_pkg::STAT_EMPTY;
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                            n_idx    = '0;
                        end
                        default: begin
                            n_status = r_status;
                        end
                    endcase
                end
            end
            olad_pkg::S_SEARCH: begin
                // The read data belongs to r_idx; the next read goes out now.
                rd_en   = 1'b1;
                rd_addr = IW'(CW'(r_idx) + CW'(1));
                if (!match) begin
                    if (at_last) begin
                        rd_en    = 1'b0;
                        n_status = olad_pkg::STAT_NOTFOUND;
                    end else begin
                        n_idx = IW'(CW'(r_idx) + CW'(1));
                    end
                end
            end
            olad_pkg::S_SHIFT: begin
                // r_q holds the entry behind r_idx; move it up one place.
                if (at_last) begin
                    n_count  = r_count - CW'(1);
                    n_status = olad_pkg::STAT_OK;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = r_q;
                    rd_en   = 1'b1;
                    rd_addr = IW'(CW'(r_idx) + CW'(2));
                    n_idx   = IW'(CW'(r_idx) + CW'(1));
                end
            end
            olad_pkg::S_LIST: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_item = r_q;
                    emit_last = at_last;
                    n_status  = olad_pkg::STAT_OK;
                    if (!at_last) begin
                        rd_en   = 1'b1;
                        rd_addr = IW'(CW'(r_idx) + CW'(1));
                        n_idx   = IW'(CW'(r_idx) + CW'(1));
                    end
                end
            end
            olad_pkg::S_RESP: begin
                emit = out_free;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // RAM with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olad_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers without reset.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        if (accept) begin
            r_value <= i_value;
        end
    end

    // Output register: loads a transfer when one is produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item   <= emit_item;
            r_out_last   <= emit_last;
            r_out_status <= (r_state == olad_pkg::S_LIST) ? olad_pkg::STAT_OK : r_status;
        end
    end

endmodule

[tb/sv/olad_list_checker.sv]
`timescale 1ns / 1ps

module olad_list_checker #(
    parameter int DEPTH = olad_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic signed [31:0] i_item,
    input  logic               i_last,
    input  logic [1:0]         i_status,
    output int                 o_error_count,
    output int                 o_outstanding
);
    import olad_pkg::*;

    // One response transfer as the list should produce it.
    typedef struct packed {
        logic [31:0] item;
        logic        last;
        logic [1:0]  status;
    } t_reply;

    // Shadow copy of the list contents and of its fill level.
    logic [31:0] shadow_items [DEPTH];
    int          shadow_count = 0;

    // Predicted responses, oldest first.
    t_reply awaited_replies [$];

    int error_count = 0;
    int outstanding = 0;

    assign o_error_count = error_count;
    assign o_outstanding = outstanding;

    task automatic queue_reply(input logic [31:0] item, input logic last,
                               input logic [1:0] status);
        t_reply r;
        r.item   = item;
        r.last   = last;
        r.status = status;
        awaited_replies.push_back(r);
    endtask

    // Works out the responses of one request and updates the shadow list.
    task automatic apply_request(input logic [1:0] action, input logic [31:0] value);
        int hit;
        hit = -1;
        case (action)
            ACT_APPEND: begin
                if (shadow_count >= DEPTH) begin
                    queue_reply('0, 1'b1, STAT_FULL);
                end else begin
                    shadow_items[shadow_count] = value;
                    shadow_count++;
                    queue_reply('0, 1'b1, STAT_OK);
                end
            end
            ACT_DELETE: begin
                if (shadow_count == 0) begin
                    queue_reply('0, 1'b1, STAT_EMPTY);
                end else begin
                    // Only the first equal entry goes; the rest move up one place.
                    for (int i = 0; i < shadow_count; i++) begin
                        if (hit < 0 && shadow_items[i] == value) hit = i;
                    end
                    if (hit < 0) begin
                        queue_reply('0, 1'b1, STAT_NOTFOUND);
                    end else begin
                        for (int i = hit; i + 1 < shadow_count; i++) begin
                            shadow_items[i] = shadow_items[i + 1];
                        end
                        shadow_count--;
                        queue_reply('0, 1'b1, STAT_OK);
                    end
                end
            end
            ACT_LIST: begin
                if (shadow_count == 0) begin
                    queue_reply('0, 1'b1, STAT_EMPTY);
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        queue_reply(shadow_items[i], i == shadow_count - 1, STAT_OK);
                    end
                end
            end
            default: begin
                // The spare action code is dropped without a response.
            end
        endcase
    endtask

    // Compares one response transfer with the oldest prediction.
    task automatic check_reply();
        t_reply want;
        if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected response: expected none, got item %0d last %0b status %0d",
                     $time, i_item, i_last, i_status);
            error_count++;
        end else begin
            want = awaited_replies.pop_front();
            if (want.item !== i_item || want.last !== i_last || want.status !== i_status) begin
                $display("%0t: response mismatch: expected item %0d last %0b status %0d",
                         $time, $signed(want.item), want.last, want.status);
                $display("%0t:                    got item %0d last %0b status %0d",
                         $time, i_item, i_last, i_status);
                error_count++;
            end
        end
    endtask

    // Responses are checked before a request of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_replies.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) check_reply();
            if (i_req_valid && i_req_ready) apply_request(i_action, i_value);
        end
        outstanding = awaited_replies.size();
    end

endmodule

[tb/sv/ordered_list_append_delete_tb.sv]
`timescale 1ns / 1ps

module ordered_list_append_delete_tb;
    import olad_pkg::*;

    localparam int          DEPTH        = DEPTH_DEFAULT;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_action;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_item;
    logic               o_last;
    logic [1:0]         o_status;

    int error_count;
    int outstanding;
    int cycle_count = 0;

    // Random idling of each side, and a one-off long stall of the receiver.
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit rx_hold = 1'b0;

    ordered_list_append_delete #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_action(i_action),
        .i_value (i_value),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .o_last  (o_last),
        .o_status(o_status)
    );

    olad_list_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_action     (i_action),
        .i_value      (i_value),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (i_ready),
        .i_item       (o_item),
        .i_last       (o_last),
        .i_status     (o_status),
        .o_error_count(error_count),
        .o_outstanding(outstanding)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: mostly ready, random short stalls, one long hold-off on request.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold = 1'b0;
            end else begin
                i_ready = !(rx_gaps && $urandom_range(0, 99) < 9);
            end
        end
    end

    // Offers one request and returns at the falling edge after its transfer.
    task automatic send_request(input logic [1:0] action, input logic [31:0] value);
        while (tx_gaps && $urandom_range(0, 99) < 9) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_action = action;
        i_value  = value;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Holds the sender back until every predicted response has arrived.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [1:0]  action;
        logic [31:0] value;
        logic [31:0] pool [6];
        int          sent;
        int          phase;
        int          phase_len;
        int          append_pct;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_action = ACT_APPEND;
        i_value  = '0;
        sent     = 0;
        phase    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty-list cases, extremes, duplicates, head, middle
        // and tail removal, the ignored code, and a miss.
        send_request(ACT_LIST, 32'd0);
        send_request(ACT_DELETE, 32'd5);
        send_request(ACT_UNUSED, 32'hffff_ffff);
        send_request(ACT_APPEND, VAL_MIN);
        send_request(ACT_APPEND, VAL_MAX);
        send_request(ACT_APPEND, 32'd0);
        send_request(ACT_APPEND, 32'hffff_ffff);
        send_request(ACT_APPEND, VAL_MIN);
        send_request(ACT_APPEND, 32'h5555_5555);
        send_request(ACT_LIST, 32'h1234_5678);
        send_request(ACT_DELETE, 32'd123);
        send_request(ACT_DELETE, VAL_MIN);
        send_request(ACT_DELETE, 32'h5555_5555);
        send_request(ACT_DELETE, 32'hffff_ffff);
        send_request(ACT_LIST, 32'd0);
        send_request(ACT_DELETE, VAL_MAX);
        send_request(ACT_DELETE, VAL_MIN);
        send_request(ACT_DELETE, 32'd0);
        send_request(ACT_LIST, 32'd0);
        send_request(ACT_APPEND, 32'haaaa_aaaa);
        send_request(ACT_DELETE, 32'haaaa_aaaa);
        wait_drained();

        // Random part: phases with their own value pool and append weight, so
        // that the list fills up, runs dry and sees many repeated values.
        while (sent < RANDOM_ITEMS) begin
            for (int j = 0; j < 6; j++) pool[j] = $urandom;
            if ($urandom_range(0, 3) == 0) begin
                pool[0] = VAL_MIN;
                pool[1] = VAL_MAX;
            end
            case ($urandom_range(0, 3))
                0: append_pct = 25;
                1: append_pct = 50;
                2: append_pct = 75;
                default: append_pct = 90;
            endcase
            phase_len = $urandom_range(15, 50);
            if (phase == 0) append_pct = 60;
            if (phase == 1) begin
                append_pct = 95;
                phase_len  = 40;
            end
            // One phase runs with neither side idling.
            tx_gaps = (phase != 2);
            rx_gaps = (phase != 2);

            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                if (phase == 1 && k == 5) rx_hold = 1'b1;
                if ($urandom_range(0, 99) < 3) action = ACT_UNUSED;
                else if ($urandom_range(0, 99) < append_pct) action = ACT_APPEND;
                else if ($urandom_range(0, 3) == 0) action = ACT_LIST;
                else action = ACT_DELETE;
                value = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)] : $urandom;
                send_request(action, value);
                if (action != ACT_UNUSED) sent++;
            end

            if (phase == 0 || $urandom_range(0, 1) == 1) wait_drained();
            phase++;
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // Let the last responses come out, then give the block time to settle.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
